/* rtl/ssc_pkg.sv */
// Shared types, constants and helper functions for the strain and stress selector.
// Depends on nothing; every rtl file imports it.
package ssc_pkg;

	// Fixed-point format of tensor entries and results.
	localparam int unsigned FRAC_BITS = 16;

	// Number of square root pipeline stages (two result bits per stage, one in the last).
	localparam int unsigned SQ_STAGES = 16;

	// Component codes of the selection register.
	localparam logic [3:0] COMP_E00 = 4'd0;
	localparam logic [3:0] COMP_E11 = 4'd1;
	localparam logic [3:0] COMP_E22 = 4'd2;
	localparam logic [3:0] COMP_E12 = 4'd3;
	localparam logic [3:0] COMP_E02 = 4'd4;
	localparam logic [3:0] COMP_E01 = 4'd5;
	localparam logic [3:0] COMP_S00 = 4'd6;
	localparam logic [3:0] COMP_S01 = 4'd11;
	localparam logic [3:0] COMP_DET = 4'd12;
	localparam logic [3:0] COMP_VM  = 4'd13;

	typedef logic signed [31:0] fix_t;

	// One finished result.
	typedef struct packed {
		logic [31:0] value;
		logic        sat;
		logic        bad;
	} res_t;

	// Result of the non von Mises paths, tagged for the final merge.
	typedef struct packed {
		res_t res;
		logic vm;
	} oth_t;

	// Square root working state.
	typedef struct packed {
		logic [33:0] rem;
		logic [30:0] root;
	} sq_t;

	// Row and column of a symmetric component index (E00 E11 E22 E12 E02 E01).
	function automatic logic [1:0] comp_row(input logic [2:0] m);
		logic [1:0] r;
		case (m)
			3'd1: r = 2'd1;
			3'd2: r = 2'd2;
			3'd3: r = 2'd1;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] comp_col(input logic [2:0] m);
		logic [1:0] c;
		case (m)
			3'd1: c = 2'd1;
			3'd2: c = 2'd2;
			3'd3: c = 2'd2;
			3'd4: c = 2'd2;
			3'd5: c = 2'd1;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

	// Round to nearest with ties up, shift right arithmetically, saturate to 32 bits.
	function automatic res_t sat_round(input logic signed [99:0] x, input int unsigned sh);
		logic signed [100:0] y;
		res_t r;
		y = ($signed({x[99], x}) + (101'sd1 <<< (sh - 1))) >>> sh;
		if (y > 101'sd2147483647) begin
			r = '{value: 32'h7FFF_FFFF, sat: 1'b1, bad: 1'b0};
		end else if (y < -101'sd2147483648) begin
			r = '{value: 32'h8000_0000, sat: 1'b1, bad: 1'b0};
		end else begin
			r = '{value: y[31:0], sat: 1'b0, bad: 1'b0};
		end
		return r;
	endfunction

	// One restoring square root step: bring down two radicand bits, try a one bit.
	function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] pair);
		logic [33:0] r2;
		logic [33:0] trial;
		sq_t o;
		r2    = {s.rem[31:0], pair};
		trial = {1'b0, s.root, 2'b01};
		if (r2 >= trial) begin
			o.rem  = r2 - trial;
			o.root = {s.root[29:0], 1'b1};
		end else begin
			o.rem  = r2;
			o.root = {s.root[29:0], 1'b0};
		end
		return o;
	endfunction

endpackage

/* rtl/strain_stress_component_select_top.sv */
// Top level of the strain and stress selector: full datapath in one pipeline.
// Depends on ssc_pkg for types, component codes and arithmetic helpers.
//
// Usage:
//   A request is one 3x3 tensor in signed Q16.16 on t_r0c0 .. t_r2c2, taken at a
//   rising edge with start high and busy low. busy is always low: one request can
//   enter in every cycle. The config channel (cfg_valid, cfg_ready, cfg_data)
//   writes the 4-bit component code; cfg_ready is always high. Write it only
//   while no request is in flight.
//   Each request gives exactly one result on value, saturated and bad_component,
//   shown for one cycle with done high.
//   Latency is set by the von Mises square root, which resolves two root bits in
//   each of 16 stages but the last, which resolves one, after a four stage multiply
//   and sum front end; the other components ride a delay line next to it.
//   Throughput is one result per cycle. The receiver cannot stall, so nothing is
//   ever held back. Reset clears the valid bits of the pipeline and sets the
//   component code to strain E00; requests in flight at reset are dropped.
module strain_stress_component_select_top
	import ssc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  fix_t        t_r0c0,
	input  fix_t        t_r0c1,
	input  fix_t        t_r0c2,
	input  fix_t        t_r1c0,
	input  fix_t        t_r1c1,
	input  fix_t        t_r1c2,
	input  fix_t        t_r2c0,
	input  fix_t        t_r2c1,
	input  fix_t        t_r2c2,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	output logic        done,
	output fix_t        value,
	output logic        saturated,
	output logic        bad_component
);

	localparam logic signed [66:0] ONE_SQ = 67'sd1 <<< (2 * FRAC_BITS);
	localparam int unsigned OTH_DLY = SQ_STAGES - 3;

	logic [3:0]  component_q;
	logic [20:1] vld_s;
	logic        done_q;
	res_t        out_q;

	fix_t t_in [3][3];
	fix_t t_s1 [3][3];
	fix_t fi_s1 [3];
	fix_t fj_s1 [3];
	logic signed [32:0] va_s1, vb_s1, ve_s1;
	logic [3:0]  code_s1, code_s2, code_s3, code_s4, code_s5, code_s6;
	logic        diag_s1, diag_s2;
	fix_t        stv_s1, stv_s2, stv_s3, stv_s4, stv_s5, stv_s6;

	logic signed [63:0] sp_s2 [3];
	logic signed [63:0] dp_s2 [6];
	fix_t               dc_s2 [6];
	logic [64:0]        vq_s2 [3];
	logic [62:0]        vh_s2 [3];

	logic signed [66:0] acc_s3;
	logic signed [63:0] hi_s3 [6];
	logic signed [64:0] lo_s3 [6];
	logic [66:0]        vqs_s3;
	logic [64:0]        vhs_s3;

	res_t               str_s4, str_s5, str_s6;
	logic signed [96:0] dt_s4 [6];
	logic [61:0]        rad_s4;
	logic               vsat_s4;
	logic [68:0]        tot;

	logic signed [97:0] dpr_s5 [3];
	logic signed [99:0] det_s6;
	oth_t               oth_s7;
	oth_t               oth_dl [OTH_DLY];

	sq_t         sq_s   [SQ_STAGES];
	sq_t         sq_nxt [SQ_STAGES];
	logic [61:0] sq_rad_s [SQ_STAGES];
	logic        sq_sat_s [SQ_STAGES];

	logic [2:0]  str_m;
	logic [2:0]  sts_m;
	logic [3:0]  sts_code;

	// Handshake: the pipeline never stalls.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	assign t_in[0][0] = t_r0c0;
	assign t_in[0][1] = t_r0c1;
	assign t_in[0][2] = t_r0c2;
	assign t_in[1][0] = t_r1c0;
	assign t_in[1][1] = t_r1c1;
	assign t_in[1][2] = t_r1c2;
	assign t_in[2][0] = t_r2c0;
	assign t_in[2][1] = t_r2c1;
	assign t_in[2][2] = t_r2c2;

	// Component register and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			component_q <= COMP_E00;
			vld_s       <= '0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				component_q <= cfg_data;
			end
			vld_s  <= {vld_s[19:1], start && !busy};
			done_q <= vld_s[20];
		end
	end

	// Index decode for the strain columns and the stress entry.
	assign str_m    = component_q[2:0];
	assign sts_code = component_q - COMP_S00;
	assign sts_m    = sts_code[2:0];

	// Stage 1: capture the tensor, pick strain columns and the stress entry, form von Mises differences.
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				t_s1[r][c] <= t_in[r][c];
			end
			fi_s1[r] <= t_in[r][comp_row(str_m)];
			fj_s1[r] <= t_in[r][comp_col(str_m)];
		end
		va_s1   <= 33'(t_r0c0) - 33'(t_r1c1);
		vb_s1   <= 33'(t_r2c2) - 33'(t_r1c1);
		ve_s1   <= 33'(t_r0c0) - 33'(t_r2c2);
		code_s1 <= component_q;
		diag_s1 <= (component_q <= COMP_E22);
		stv_s1  <= t_in[comp_row(sts_m)][comp_col(sts_m)];
	end

	// Stage 2: all products, 32 by 32 on entries and 33 by 33 on the differences.
	always_ff @(posedge clk) begin
		logic signed [65:0] sq;
		logic signed [63:0] sh;
		for (int k = 0; k < 3; k++) begin
			sp_s2[k] <= fi_s1[k] * fj_s1[k];
		end
		dp_s2[0] <= t_s1[0][0] * t_s1[1][1];
		dp_s2[1] <= t_s1[0][0] * t_s1[1][2];
		dp_s2[2] <= t_s1[0][1] * t_s1[1][0];
		dp_s2[3] <= t_s1[0][1] * t_s1[1][2];
		dp_s2[4] <= t_s1[0][2] * t_s1[1][0];
		dp_s2[5] <= t_s1[0][2] * t_s1[1][1];
		dc_s2[0] <= t_s1[2][2];
		dc_s2[1] <= t_s1[2][1];
		dc_s2[2] <= t_s1[2][2];
		dc_s2[3] <= t_s1[2][0];
		dc_s2[4] <= t_s1[2][1];
		dc_s2[5] <= t_s1[2][0];
		sq = va_s1 * va_s1;
		vq_s2[0] <= sq[64:0];
		sq = vb_s1 * vb_s1;
		vq_s2[1] <= sq[64:0];
		sq = ve_s1 * ve_s1;
		vq_s2[2] <= sq[64:0];
		sh = t_s1[0][1] * t_s1[0][1];
		vh_s2[0] <= sh[62:0];
		sh = t_s1[2][1] * t_s1[2][1];
		vh_s2[1] <= sh[62:0];
		sh = t_s1[0][2] * t_s1[0][2];
		vh_s2[2] <= sh[62:0];
		code_s2 <= code_s1;
		diag_s2 <= diag_s1;
		stv_s2  <= stv_s1;
	end

	// Stage 3: strain sum, determinant partial products, von Mises sums.
	always_ff @(posedge clk) begin
		acc_s3 <= 67'(sp_s2[0]) + 67'(sp_s2[1]) + 67'(sp_s2[2])
			- (diag_s2 ? ONE_SQ : 67'sd0);
		for (int k = 0; k < 6; k++) begin
			hi_s3[k] <= $signed(dp_s2[k][63:32]) * dc_s2[k];
			lo_s3[k] <= $signed({1'b0, dp_s2[k][31:0]}) * dc_s2[k];
		end
		vqs_s3  <= 67'(vq_s2[0]) + 67'(vq_s2[1]) + 67'(vq_s2[2]);
		vhs_s3  <= 65'(vh_s2[0]) + 65'(vh_s2[1]) + 65'(vh_s2[2]);
		code_s3 <= code_s2;
		stv_s3  <= stv_s2;
	end

	// Von Mises sum: squared differences plus six times the shear squares; stage 4 halves it.
	assign tot = 69'(vqs_s3) + (69'(vhs_s3) << 2) + (69'(vhs_s3) << 1);

	// Stage 4: strain rounding, determinant terms, radicand range check.
	always_ff @(posedge clk) begin
		str_s4 <= sat_round(100'(acc_s3), FRAC_BITS + 1);
		for (int k = 0; k < 6; k++) begin
			dt_s4[k] <= (97'(hi_s3[k]) <<< 32) + 97'(lo_s3[k]);
		end
		rad_s4  <= tot[62:1];
		vsat_s4 <= |tot[68:63];
		code_s4 <= code_s3;
		stv_s4  <= stv_s3;
	end

	// Stage 5 and 6: signed sum of the six determinant terms.
	always_ff @(posedge clk) begin
		dpr_s5[0] <= 98'(dt_s4[0]) - 98'(dt_s4[1]);
		dpr_s5[1] <= 98'(dt_s4[3]) - 98'(dt_s4[2]);
		dpr_s5[2] <= 98'(dt_s4[4]) - 98'(dt_s4[5]);
		det_s6    <= 100'(dpr_s5[0]) + 100'(dpr_s5[1]) + 100'(dpr_s5[2]);
		str_s5    <= str_s4;
		str_s6    <= str_s5;
		stv_s5    <= stv_s4;
		stv_s6    <= stv_s5;
		code_s5   <= code_s4;
		code_s6   <= code_s5;
	end

	// Stage 7: round the determinant and select among the non von Mises results.
	always_ff @(posedge clk) begin
		oth_s7.vm <= (code_s6 == COMP_VM);
		case (code_s6) inside
			[COMP_E00:COMP_E01]: oth_s7.res <= str_s6;
			[COMP_S00:COMP_S01]: oth_s7.res <= '{value: stv_s6, sat: 1'b0, bad: 1'b0};
			COMP_DET:            oth_s7.res <= sat_round(det_s6, 2 * FRAC_BITS);
			COMP_VM:             oth_s7.res <= '{value: 32'd0, sat: 1'b0, bad: 1'b0};
			default:             oth_s7.res <= '{value: 32'd0, sat: 1'b0, bad: 1'b1};
		endcase
	end

	// Delay line that keeps the selected result level with the square root.
	always_ff @(posedge clk) begin
		oth_dl[0] <= oth_s7;
		for (int k = 1; k < OTH_DLY; k++) begin
			oth_dl[k] <= oth_dl[k - 1];
		end
	end

	// Square root pipeline: two root bits per stage but the last, most significant first.
	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sq
		localparam int B0 = 30 - 2 * j;
		localparam int B1 = 29 - 2 * j;

		if (j == 0) begin : g_first
			// First two steps start from an empty root.
			always_comb begin
				sq_t s;
				s = '{rem: 34'd0, root: 31'd0};
				s = sqrt_step(s, rad_s4[2 * B0 + 1 -: 2]);
				s = sqrt_step(s, rad_s4[2 * B1 + 1 -: 2]);
				sq_nxt[j] = s;
			end

			always_ff @(posedge clk) begin
				sq_s[j]     <= sq_nxt[j];
				sq_rad_s[j] <= rad_s4;
				sq_sat_s[j] <= vsat_s4;
			end
		end else if (B1 >= 0) begin : g_mid
			// Two steps of the restoring method on the previous stage's state.
			always_comb begin
				sq_t s;
				s = sq_s[j - 1];
				s = sqrt_step(s, sq_rad_s[j - 1][2 * B0 + 1 -: 2]);
				s = sqrt_step(s, sq_rad_s[j - 1][2 * B1 + 1 -: 2]);
				sq_nxt[j] = s;
			end

			always_ff @(posedge clk) begin
				sq_s[j]     <= sq_nxt[j];
				sq_rad_s[j] <= sq_rad_s[j - 1];
				sq_sat_s[j] <= sq_sat_s[j - 1];
			end
		end else begin : g_last
			// The last stage resolves the least significant root bit only.
			always_comb begin
				sq_t s;
				s = sq_s[j - 1];
				s = sqrt_step(s, sq_rad_s[j - 1][2 * B0 + 1 -: 2]);
				sq_nxt[j] = s;
			end

			always_ff @(posedge clk) begin
				sq_s[j]     <= sq_nxt[j];
				sq_rad_s[j] <= sq_rad_s[j - 1];
				sq_sat_s[j] <= sq_sat_s[j - 1];
			end
		end
	end

	// Output register: merge the von Mises root with the other paths.
	always_ff @(posedge clk) begin
		if (!oth_dl[OTH_DLY - 1].vm) begin
			out_q <= oth_dl[OTH_DLY - 1].res;
		end else if (sq_sat_s[SQ_STAGES - 1]) begin
			out_q <= '{value: 32'h7FFF_FFFF, sat: 1'b1, bad: 1'b0};
		end else begin
			out_q <= '{value: {1'b0, sq_s[SQ_STAGES - 1].root}, sat: 1'b0, bad: 1'b0};
		end
	end

	assign done          = done_q;
	assign value         = out_q.value;
	assign saturated     = out_q.sat;
	assign bad_component = out_q.bad;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for the strain and stress selector: directed and random tensors under every
// component code, checked against an in-bench predictor. Depends on ssc_pkg and the top.
module tb_top;
	import ssc_pkg::*;

	localparam int LATENCY = 21;

	// One expected result.
	typedef struct {
		logic [31:0] value;
		logic        sat;
		logic        bad;
	} exp_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	fix_t        t_r0c0, t_r0c1, t_r0c2, t_r1c0, t_r1c1, t_r1c2, t_r2c0, t_r2c1, t_r2c2;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;
	logic        done;
	fix_t        value;
	logic        saturated;
	logic        bad_component;

	logic [3:0]  cur_component;
	exp_t        expected_results[$];
	int          error_count;

	strain_stress_component_select_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.t_r0c0(t_r0c0), .t_r0c1(t_r0c1), .t_r0c2(t_r0c2),
		.t_r1c0(t_r1c0), .t_r1c1(t_r1c1), .t_r1c2(t_r1c2),
		.t_r2c0(t_r2c0), .t_r2c1(t_r2c1), .t_r2c2(t_r2c2),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .value(value), .saturated(saturated), .bad_component(bad_component)
	);

	// Clock generator.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit.
	initial begin
		#5ms;
		$display("FAIL strain_stress_component_select_top");
		$finish;
	end

	// Round to nearest with ties up, shift right, saturate to 32 bits.
	function automatic exp_t round_saturate(input logic signed [127:0] x, input int sh);
		logic signed [127:0] y;
		exp_t r;
		y = (x + (128'sd1 <<< (sh - 1))) >>> sh;
		r.bad = 1'b0;
		if (y > 128'sd2147483647) begin
			r.value = 32'h7FFF_FFFF;
			r.sat   = 1'b1;
		end else if (y < -128'sd2147483648) begin
			r.value = 32'h8000_0000;
			r.sat   = 1'b1;
		end else begin
			r.value = y[31:0];
			r.sat   = 1'b0;
		end
		return r;
	endfunction

	// Expected strain, stress, det F or von Mises value for one tensor.
	function automatic exp_t predict_component(input logic [3:0] comp,
			input logic signed [31:0] t[3][3]);
		logic signed [127:0] w[3][3];
		logic signed [127:0] acc, a, b, e, tot;
		logic [127:0] half, root, cand;
		int i, j;
		int rows[6];
		int cols[6];
		exp_t r;
		rows = '{0, 1, 2, 1, 0, 0};
		cols = '{0, 1, 2, 2, 2, 1};
		for (int p = 0; p < 3; p++)
			for (int q = 0; q < 3; q++)
				w[p][q] = t[p][q];
		r = '{value: 32'd0, sat: 1'b0, bad: 1'b0};
		if (comp <= COMP_E01) begin
			i = rows[comp];
			j = cols[comp];
			acc = w[0][i] * w[0][j] + w[1][i] * w[1][j] + w[2][i] * w[2][j];
			if (i == j)
				acc = acc - (128'sd1 <<< (2 * FRAC_BITS));
			r = round_saturate(acc, FRAC_BITS + 1);
		end else if (comp <= COMP_S01) begin
			r.value = t[rows[comp - COMP_S00]][cols[comp - COMP_S00]];
		end else if (comp == COMP_DET) begin
			acc = w[0][0] * w[1][1] * w[2][2] - w[0][0] * w[1][2] * w[2][1]
				- w[0][1] * w[1][0] * w[2][2] + w[0][1] * w[1][2] * w[2][0]
				+ w[0][2] * w[1][0] * w[2][1] - w[0][2] * w[1][1] * w[2][0];
			r = round_saturate(acc, 2 * FRAC_BITS);
		end else if (comp == COMP_VM) begin
			// The shear term uses S21, as the block does.
			a = w[0][0] - w[1][1];
			b = w[2][2] - w[1][1];
			e = w[0][0] - w[2][2];
			tot = a * a + b * b + e * e
				+ 6 * (w[0][1] * w[0][1] + w[2][1] * w[2][1] + w[0][2] * w[0][2]);
			half = tot >>> 1;
			if (half >= (128'd1 << 62)) begin
				r.value = 32'h7FFF_FFFF;
				r.sat   = 1'b1;
			end else begin
				root = 0;
				for (int k = 30; k >= 0; k--) begin
					cand = root | (128'd1 << k);
					if (cand * cand <= half)
						root = cand;
				end
				r.value = root[31:0];
			end
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

	// Random idle cycles, mostly short with a few long gaps; start drops while idle.
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) < 6) ? 0 : (($urandom_range(0, 19) == 0) ?
			$urandom_range(10, 40) : $urandom_range(1, 3));
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Send one tensor request and queue its expected result.
	task automatic send_tensor(input logic signed [31:0] t[3][3], input bit gaps);
		if (gaps)
			idle_gap();
		start  <= 1'b1;
		t_r0c0 <= t[0][0]; t_r0c1 <= t[0][1]; t_r0c2 <= t[0][2];
		t_r1c0 <= t[1][0]; t_r1c1 <= t[1][1]; t_r1c2 <= t[1][2];
		t_r2c0 <= t[2][0]; t_r2c1 <= t[2][1]; t_r2c2 <= t[2][2];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_results.push_back(predict_component(cur_component, t));
	endtask

	// Wait for every result, then write the component code.
	task automatic set_component(input logic [3:0] comp);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= comp;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid     <= 1'b0;
		cur_component <= comp;
		@(posedge clk);
	endtask

	// Random entry: small magnitudes near unity mostly, full range sometimes.
	function automatic logic [31:0] random_entry();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h8000_0000 | $urandom_range(0, 3);
			2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
		endcase
	endfunction

	task automatic random_tensor(output logic signed [31:0] t[3][3]);
		for (int p = 0; p < 3; p++)
			for (int q = 0; q < 3; q++)
				t[p][q] = random_entry();
	endtask

	// Directed: identity, min on all codes (unused too); max, all-ones on strain, det, VM.
	task automatic test_directed();
		logic signed [31:0] t[3][3];
		for (int c = 0; c < 16; c++) begin
			set_component(c[3:0]);
			for (int p = 0; p < 3; p++)
				for (int q = 0; q < 3; q++)
					t[p][q] = (p == q) ? 32'sh0001_0000 : 32'sd0;
			send_tensor(t, 1'b0);
			t = '{default: 32'sh8000_0000};
			send_tensor(t, 1'b0);
			if (c == 12 || c == 13 || c < 6) begin
				t = '{default: 32'sh7FFF_FFFF};
				send_tensor(t, 1'b0);
				t = '{default: -32'sd1};
				send_tensor(t, 1'b0);
			end
		end
	endtask

	// Random tensors in bursts under random codes, edges of the range included.
	task automatic test_random();
		logic signed [31:0] t[3][3];
		logic [3:0] comp;
		for (int burst = 0; burst < 20; burst++) begin
			comp = (burst < 2) ? 4'(burst * 15) : 4'($urandom_range(0, 15));
			set_component(comp);
			for (int n = 0; n < 25; n++) begin
				random_tensor(t);
				send_tensor(t, (burst % 3) != 0);
			end
		end
	endtask

	// Result checker.
	always @(posedge clk) begin
		exp_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result value %h", $time, value);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (value !== want.value || saturated !== want.sat
						|| bad_component !== want.bad) begin
					$display("%0t: expected value %h sat %b bad %b, got %h %b %b", $time,
						want.value, want.sat, want.bad, value, saturated, bad_component);
					error_count++;
				end
			end
		end
	end

	initial begin
		error_count   = 0;
		cur_component = COMP_E00;
		arst_n        = 1'b0;
		start         = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		{t_r0c0, t_r0c1, t_r0c2, t_r1c0, t_r1c1, t_r1c2, t_r2c0, t_r2c1, t_r2c2} = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (error_count == 0)
			$display("PASS strain_stress_component_select_top");
		else
			$display("FAIL strain_stress_component_select_top");
		$finish;
	end

endmodule

/* filelist.f */
rtl/ssc_pkg.sv
rtl/strain_stress_component_select_top.sv
tb/sv/tb_top.sv
